// File: rtl/core/encoder_travel_balance_drive_assert.svh
// Assertion macros used by the checker of the travel balance drive.
`ifndef ENCODER_TRAVEL_BALANCE_DRIVE_ASSERT_SVH
`define ENCODER_TRAVEL_BALANCE_DRIVE_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define ETBD_ASSERT_IMPLY(name, clk, rst, cause, effect) \
   name: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
      else $error("etbd check failed: %m");

// Next-cycle implication, switched off while reset is high.
`define ETBD_ASSERT_NEXT(name, clk, rst, cause, effect) \
   name: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error("etbd check failed: %m");

`endif

// File: rtl/core/etbd_pkg.sv
// Shared constants, codes and types of the travel balance drive.
package etbd_pkg;

   // Field and counter widths.
   localparam int COUNT_BITS  = 24;
   localparam int DIST_BITS   = 23;
   localparam int SPEED_BITS  = 7;
   localparam int BOOST_BITS  = 6;
   localparam int DRIVE_BITS  = 8;
   localparam int TRAVEL_BITS = 24;
   localparam int CMD_BITS    = 2;
   localparam int ADDR_BITS   = 4;
   localparam int DATA_BITS   = 32;

   // Derived widths for the count arithmetic.
   localparam int CMP_BITS  = (COUNT_BITS - 1 > DIST_BITS) ? COUNT_BITS - 1 : DIST_BITS;
   localparam int ERR_BITS  = COUNT_BITS + 1;
   localparam int WIDE_BITS = (COUNT_BITS > TRAVEL_BITS) ? COUNT_BITS : TRAVEL_BITS;

   // Division by three of a small error: floor(m / 3) = (m * 171) >> 9 for m < 384.
   // Errors of 384 or more always push the corrected speed past any limit.
   localparam int DIV_SPAN      = 384;
   localparam int DIV_IN_BITS   = 9;
   localparam int DIV_MULT      = 171;
   localparam int DIV_MULT_BITS = 8;
   localparam int DIV_SHIFT     = 9;
   localparam int DIV_PROD_BITS = DIV_IN_BITS + DIV_MULT_BITS;

   // Saturation bounds.
   localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS - 1){1'b1}}};
   localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = -COUNT_MAX;
   localparam logic signed [WIDE_BITS-1:0]  TRAVEL_MAX =
      WIDE_BITS'({1'b0, {(TRAVEL_BITS - 1){1'b1}}});
   localparam logic signed [WIDE_BITS-1:0]  TRAVEL_MIN = -TRAVEL_MAX;
   localparam logic [SPEED_BITS-1:0]        SPEED_MAX = {SPEED_BITS{1'b1}};

   // Reset values of the registers and the kept speeds.
   localparam logic [DIST_BITS-1:0]  DIST_RESET  = DIST_BITS'(1000);
   localparam logic [SPEED_BITS-1:0] BASE_RESET  = SPEED_BITS'(64);
   localparam logic [SPEED_BITS-1:0] LIMIT_RESET = SPEED_BITS'(90);
   localparam logic [BOOST_BITS-1:0] BOOST_RESET = BOOST_BITS'(32);
   localparam logic [SPEED_BITS-1:0] SPEED_RESET = SPEED_BITS'(64);

   // Command codes of the input item; the fourth code is a no-operation.
   typedef enum logic [CMD_BITS-1:0] {
      CMD_EDGE  = 2'd0,
      CMD_START = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   // Register indexes, taken from the word address.
   typedef enum logic [1:0] {
      REG_MOVE_DISTANCE = 2'd0,
      REG_BASE_SPEED    = 2'd1,
      REG_SPEED_LIMIT   = 2'd2,
      REG_SPEED_BOOST   = 2'd3
   } reg_type;

   typedef struct packed {
      logic [DIST_BITS-1:0]  move_distance;
      logic [SPEED_BITS-1:0] base_speed;
      logic [SPEED_BITS-1:0] speed_limit;
      logic [BOOST_BITS-1:0] speed_boost;
   } cfg_type;

   typedef struct packed {
      logic [CMD_BITS-1:0] command;
      logic                wheel_select;
      logic                phase_b_level;
   } item_type;

   typedef struct packed {
      logic signed [DRIVE_BITS-1:0]  wheel0_drive;
      logic signed [DRIVE_BITS-1:0]  wheel1_drive;
      logic                          moving;
      logic signed [TRAVEL_BITS-1:0] travel0;
      logic signed [TRAVEL_BITS-1:0] travel1;
   } rsp_type;

endpackage

// File: rtl/core/encoder_travel_balance_drive.sv
// Top level of the two-wheel travel balance drive with x1 encoder counting.
//
//   Channel   Direction  Handshake              Contents
//   req_      in         req_valid/req_ready    command, wheel select, B level
//   rsp_      out        rsp_valid/rsp_ready    drives, moving flag, two travels
//   APB       in/out     psel/penable, pready   four configuration registers
//
// One item per clock cycle is sustained while results are taken; each item
// is held in the input register and then moves to the result register,
// from which its result is offered. The core's single update pass sets that rate.
// Synchronous reset clears counts and moving flag, and reloads speeds and registers.
// A stalled result holds the core; the input register then fills and
// req_ready falls until the result is taken.
module encoder_travel_balance_drive (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [etbd_pkg::CMD_BITS-1:0]            req_command,
   input  logic                                     req_wheel_select,
   input  logic                                     req_phase_b_level,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [etbd_pkg::DRIVE_BITS-1:0]   rsp_wheel0_drive,
   output logic signed [etbd_pkg::DRIVE_BITS-1:0]   rsp_wheel1_drive,
   output logic                                     rsp_moving,
   output logic signed [etbd_pkg::TRAVEL_BITS-1:0]  rsp_travel0,
   output logic signed [etbd_pkg::TRAVEL_BITS-1:0]  rsp_travel1,
   input  logic                                     psel,
   input  logic                                     penable,
   input  logic                                     pwrite,
   input  logic [etbd_pkg::ADDR_BITS-1:0]           paddr,
   input  logic [etbd_pkg::DATA_BITS-1:0]           pwdata,
   output logic [etbd_pkg::DATA_BITS-1:0]           prdata,
   output logic                                     pready
);

   etbd_pkg::cfg_type  cfg;
   etbd_pkg::item_type item;
   etbd_pkg::rsp_type  result;
   logic               step;
   logic               out_free;

   // Configuration registers.
   etbd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Input register.
   etbd_in_stage u_in_stage (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_wheel_select  (req_wheel_select),
      .req_phase_b_level (req_phase_b_level),
      .out_free          (out_free),
      .step              (step),
      .item              (item)
   );

   // State update and result formation.
   etbd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .cfg    (cfg),
      .result (result)
   );

   // Result register.
   etbd_out_stage u_out_stage (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .result           (result),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_wheel0_drive (rsp_wheel0_drive),
      .rsp_wheel1_drive (rsp_wheel1_drive),
      .rsp_moving       (rsp_moving),
      .rsp_travel0      (rsp_travel0),
      .rsp_travel1      (rsp_travel1)
   );

endmodule

// File: rtl/core/etbd_csr.sv
// Configuration registers behind the APB-style port.
module etbd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [etbd_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [etbd_pkg::DATA_BITS-1:0]   pwdata,
   output logic [etbd_pkg::DATA_BITS-1:0]   prdata,
   output logic                             pready,
   output etbd_pkg::cfg_type                cfg
);

   etbd_pkg::cfg_type cfg_ff, cfg_in;
   etbd_pkg::reg_type reg_index;
   logic              write_en;

   assign reg_index = etbd_pkg::reg_type'(paddr[3:2]);
   assign write_en  = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   // A write lands in the addressed register at the access cycle.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            etbd_pkg::REG_MOVE_DISTANCE: cfg_in.move_distance = pwdata[etbd_pkg::DIST_BITS-1:0];
            etbd_pkg::REG_BASE_SPEED:    cfg_in.base_speed    = pwdata[etbd_pkg::SPEED_BITS-1:0];
            etbd_pkg::REG_SPEED_LIMIT:   cfg_in.speed_limit   = pwdata[etbd_pkg::SPEED_BITS-1:0];
            etbd_pkg::REG_SPEED_BOOST:   cfg_in.speed_boost   = pwdata[etbd_pkg::BOOST_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Read data is the addressed register, zero-extended.
   always_comb begin
      case (reg_index)
         etbd_pkg::REG_MOVE_DISTANCE: prdata = etbd_pkg::DATA_BITS'(cfg_ff.move_distance);
         etbd_pkg::REG_BASE_SPEED:    prdata = etbd_pkg::DATA_BITS'(cfg_ff.base_speed);
         etbd_pkg::REG_SPEED_LIMIT:   prdata = etbd_pkg::DATA_BITS'(cfg_ff.speed_limit);
         etbd_pkg::REG_SPEED_BOOST:   prdata = etbd_pkg::DATA_BITS'(cfg_ff.speed_boost);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_distance <= etbd_pkg::DIST_RESET;
         cfg_ff.base_speed    <= etbd_pkg::BASE_RESET;
         cfg_ff.speed_limit   <= etbd_pkg::LIMIT_RESET;
         cfg_ff.speed_boost   <= etbd_pkg::BOOST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/core/etbd_in_stage.sv
// Input register: holds one accepted item until the core takes it.
module etbd_in_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [etbd_pkg::CMD_BITS-1:0] req_command,
   input  logic                          req_wheel_select,
   input  logic                          req_phase_b_level,
   input  logic                          out_free,
   output logic                          step,
   output etbd_pkg::item_type            item
);

   logic               valid_ff, valid_in;
   etbd_pkg::item_type item_ff;
   logic               load;

   // The register frees up whenever the result register can take this item.
   assign req_ready = !valid_ff || out_free;
   assign step      = valid_ff && out_free;
   assign load      = req_valid && req_ready;
   assign item      = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset; it is only looked at while valid.
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.command       <= req_command;
         item_ff.wheel_select  <= req_wheel_select;
         item_ff.phase_b_level <= req_phase_b_level;
      end
   end

endmodule

// File: rtl/core/etbd_core.sv
// Wheel counters, move control and speed correction, one item per step.
module etbd_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  etbd_pkg::item_type item,
   input  etbd_pkg::cfg_type  cfg,
   output etbd_pkg::rsp_type  result
);

   localparam int CB = etbd_pkg::COUNT_BITS;
   localparam int SB = etbd_pkg::SPEED_BITS;
   localparam int EB = etbd_pkg::ERR_BITS;

   logic signed [CB-1:0] count0_ff, count0_in;
   logic signed [CB-1:0] count1_ff, count1_in;
   logic                 active_ff, active_in;
   logic                 forward_ff, forward_in;
   logic [SB-1:0]        speed0_ff, speed0_in;
   logic [SB-1:0]        speed1_ff, speed1_in;

   logic signed [CB-1:0] target;
   logic signed [CB-1:0] stepped;
   logic signed [CB-1:0] step_abs;
   logic                 count_up;
   logic                 reach;
   logic signed [EB-1:0] err;
   logic signed [EB-1:0] err_abs;
   logic [EB-1:0]        err_mag;
   logic                 err_small;
   logic [etbd_pkg::DIV_IN_BITS-1:0]   div_in;
   logic [etbd_pkg::DIV_PROD_BITS-1:0] div_prod;
   logic [SB-1:0]        div_q;
   logic [SB:0]          corr_sum;
   logic [SB-1:0]        corr;
   logic                 fix_wheel0;
   logic [SB-1:0]        boost_corr;
   logic [SB-1:0]        boost_base;

   // Speed plus boost, saturating at the largest speed.
   function automatic logic [SB-1:0] add_boost(input logic [SB-1:0] speed,
                                               input logic [etbd_pkg::BOOST_BITS-1:0] boost);
      logic [SB:0] sum;
      sum = {1'b0, speed} + (SB + 1)'(boost);
      return sum[SB] ? etbd_pkg::SPEED_MAX : sum[SB-1:0];
   endfunction

   // Signed drive from a kept speed.
   function automatic logic signed [etbd_pkg::DRIVE_BITS-1:0] to_drive(input logic [SB-1:0] speed,
                                                                     input logic negate);
      logic signed [etbd_pkg::DRIVE_BITS-1:0] mag;
      mag = etbd_pkg::DRIVE_BITS'(speed);
      return negate ? -mag : mag;
   endfunction

   // Count reported as travel, saturated to the travel field.
   function automatic logic signed [etbd_pkg::TRAVEL_BITS-1:0] to_travel(
         input logic signed [CB-1:0] count);
      logic signed [etbd_pkg::WIDE_BITS-1:0] wide;
      wide = etbd_pkg::WIDE_BITS'(count);
      if (wide > etbd_pkg::TRAVEL_MAX) begin
         wide = etbd_pkg::TRAVEL_MAX;
      end else if (wide < etbd_pkg::TRAVEL_MIN) begin
         wide = etbd_pkg::TRAVEL_MIN;
      end
      return wide[etbd_pkg::TRAVEL_BITS-1:0];
   endfunction

   // Saturating step of the edged wheel; wheel 1 counts mirrored.
   always_comb begin
      target   = item.wheel_select ? count1_ff : count0_ff;
      count_up = item.wheel_select ? !item.phase_b_level : item.phase_b_level;
      if (count_up) begin
         stepped = (target < etbd_pkg::COUNT_MAX) ? target + CB'(1) : etbd_pkg::COUNT_MAX;
      end else begin
         stepped = (target > etbd_pkg::COUNT_MIN) ? target - CB'(1) : etbd_pkg::COUNT_MIN;
      end
      step_abs = stepped[CB-1] ? -stepped : stepped;
      reach    = etbd_pkg::CMP_BITS'(step_abs[CB-2:0]) >=
                 etbd_pkg::CMP_BITS'(cfg.move_distance);
   end

   // Correction: base speed plus a third of the count difference, clamped.
   always_comb begin
      err       = EB'(count1_ff) - EB'(count0_ff);
      err_abs   = err[EB-1] ? -err : err;
      err_mag   = $unsigned(err_abs);
      err_small = err_mag < EB'(etbd_pkg::DIV_SPAN);
      div_in    = err_mag[etbd_pkg::DIV_IN_BITS-1:0];
      div_prod  = etbd_pkg::DIV_PROD_BITS'(div_in) *
                  etbd_pkg::DIV_PROD_BITS'(etbd_pkg::DIV_MULT);
      div_q     = div_prod[etbd_pkg::DIV_SHIFT+SB-1:etbd_pkg::DIV_SHIFT];
      corr_sum  = {1'b0, cfg.base_speed} + {1'b0, div_q};
      if (!err_small || (corr_sum > {1'b0, cfg.speed_limit})) begin
         corr = cfg.speed_limit;
      end else begin
         corr = corr_sum[SB-1:0];
      end
      fix_wheel0 = ((err > EB'(0)) == forward_ff);
      boost_corr = add_boost(corr, cfg.speed_boost);
      boost_base = add_boost(cfg.base_speed, cfg.speed_boost);
   end

   // Next state for the item in hand.
   always_comb begin
      count0_in  = count0_ff;
      count1_in  = count1_ff;
      active_in  = active_ff;
      forward_in = forward_ff;
      speed0_in  = speed0_ff;
      speed1_in  = speed1_ff;
      case (etbd_pkg::cmd_type'(item.command))
         etbd_pkg::CMD_EDGE: begin
            if (item.wheel_select) begin
               count1_in = stepped;
            end else begin
               count0_in = stepped;
            end
            if (reach) begin
               forward_in = active_ff ? !forward_ff : forward_ff;
               active_in  = 1'b0;
            end
         end
         etbd_pkg::CMD_START: begin
            count0_in = '0;
            count1_in = '0;
            active_in = 1'b1;
         end
         etbd_pkg::CMD_TICK: begin
            if (active_ff) begin
               speed0_in = fix_wheel0 ? boost_corr : boost_base;
               speed1_in = fix_wheel0 ? boost_base : boost_corr;
            end
         end
         default: ;
      endcase
   end

   // Result fields report the state left by this item.
   always_comb begin
      result.wheel0_drive = active_in ? to_drive(speed0_in, !forward_in) : '0;
      result.wheel1_drive = active_in ? to_drive(speed1_in, forward_in) : '0;
      result.moving       = active_in;
      result.travel0      = to_travel(count0_in);
      result.travel1      = to_travel(count1_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count0_ff  <= '0;
         count1_ff  <= '0;
         active_ff  <= 1'b0;
         forward_ff <= 1'b1;
         speed0_ff  <= etbd_pkg::SPEED_RESET;
         speed1_ff  <= etbd_pkg::SPEED_RESET;
      end else if (step) begin
         count0_ff  <= count0_in;
         count1_ff  <= count1_in;
         active_ff  <= active_in;
         forward_ff <= forward_in;
         speed0_ff  <= speed0_in;
         speed1_ff  <= speed1_in;
      end
   end

endmodule

// File: rtl/core/etbd_out_stage.sv
// Result register: holds one result until the consumer takes it.
module etbd_out_stage (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       step,
   input  etbd_pkg::rsp_type                          result,
   output logic                                       out_free,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic signed [etbd_pkg::DRIVE_BITS-1:0]     rsp_wheel0_drive,
   output logic signed [etbd_pkg::DRIVE_BITS-1:0]     rsp_wheel1_drive,
   output logic                                       rsp_moving,
   output logic signed [etbd_pkg::TRAVEL_BITS-1:0]    rsp_travel0,
   output logic signed [etbd_pkg::TRAVEL_BITS-1:0]    rsp_travel1
);

   logic              valid_ff, valid_in;
   etbd_pkg::rsp_type rsp_ff;

   // Free when empty or when the held result leaves in this cycle.
   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = step || (valid_ff && !rsp_ready);

   assign rsp_valid        = valid_ff;
   assign rsp_wheel0_drive = rsp_ff.wheel0_drive;
   assign rsp_wheel1_drive = rsp_ff.wheel1_drive;
   assign rsp_moving       = rsp_ff.moving;
   assign rsp_travel0      = rsp_ff.travel0;
   assign rsp_travel1      = rsp_ff.travel1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

endmodule

// File: rtl/core/etbd_checker.sv
// Port-level checker of the travel balance drive, bound to the top level.
`include "encoder_travel_balance_drive_assert.svh"

module etbd_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic signed [etbd_pkg::DRIVE_BITS-1:0]   rsp_wheel0_drive,
   input logic signed [etbd_pkg::DRIVE_BITS-1:0]   rsp_wheel1_drive,
   input logic                                     rsp_moving,
   input logic signed [etbd_pkg::TRAVEL_BITS-1:0]  rsp_travel0,
   input logic signed [etbd_pkg::TRAVEL_BITS-1:0]  rsp_travel1
);

   // A result waiting for transfer keeps its valid, wheel 0 drive, travel 0 and moving flag.
   `ETBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_wheel0_drive) && $stable(rsp_travel0) && $stable(rsp_moving))

   // A stopped drive reports zero on both wheels.
   `ETBD_ASSERT_IMPLY(a_stopped_zero, clock, reset, rsp_valid && !rsp_moving, rsp_wheel0_drive == 0 && rsp_wheel1_drive == 0)

   // Reported travels saturate short of the most negative code.
   `ETBD_ASSERT_IMPLY(a_travel_range, clock, reset, rsp_valid, rsp_travel0 != 24'sh800000 && rsp_travel1 != 24'sh800000)

   // No result is offered in the cycle after reset.
   `ETBD_ASSERT_IMPLY(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

endmodule

bind encoder_travel_balance_drive etbd_checker u_etbd_checker (.*);
